[design/bfge_pkg.sv]
// ----------------------------------------------------------------------------
// bfge_pkg
// Shared types and codes for the bitmap font glyph expander.
// ----------------------------------------------------------------------------
package bfge_pkg;

    localparam logic [2:0] OP_RENDER  = 3'd0;
    localparam logic [2:0] OP_LOC     = 3'd1;
    localparam logic [2:0] OP_FONT    = 3'd2;
    localparam logic [2:0] OP_SPACING = 3'd3;
    localparam logic [2:0] OP_KERNING = 3'd4;
    localparam logic [2:0] OP_PEN     = 3'd5;

    localparam logic [2:0] REG_LOW_CHAR  = 3'd0;
    localparam logic [2:0] REG_HIGH_CHAR = 3'd1;
    localparam logic [2:0] REG_MODULO    = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_BASELINE  = 3'd4;
    localparam logic [2:0] REG_SPC_EN    = 3'd5;
    localparam logic [2:0] REG_KERN_EN   = 3'd6;
    localparam logic [2:0] REG_INK       = 3'd7;

    // Strip byte address wide enough for row * modulo + byte offset.
    localparam int STRIP_AW = 20;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOCA  = 6'b000010,
        S_LOCB  = 6'b000100,
        S_LOCC  = 6'b001000,
        S_FETCH = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

[design/bfge_strip.sv]
// ----------------------------------------------------------------------------
// bfge_strip
// Packed 1-bit font strip memory with one write and one registered read port.
// Reads past the end of the strip return zero.
// ----------------------------------------------------------------------------
module bfge_strip
    import bfge_pkg::*;
#(
    parameter int FONT_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [11:0]         i_waddr,
    input  logic [7:0]          i_wdata,
    input  logic                i_re,
    input  logic [STRIP_AW-1:0] i_raddr,
    output logic [7:0]          o_rdata
);
    localparam int FA = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;

    logic [7:0] mem [FONT_BYTES];
    logic [7:0] r_q;
    logic       r_zero;

    always_ff @(posedge i_clk) begin
        if (i_we && ({8'd0, i_waddr} < 20'(FONT_BYTES))) begin
            mem[i_waddr[FA-1:0]] <= i_wdata;
        end
        if (i_re) begin
            r_zero <= (i_raddr >= STRIP_AW'(FONT_BYTES));
            r_q    <= mem[i_raddr[FA-1:0]];
        end
    end

    assign o_rdata = r_zero ? 8'h00 : r_q;

endmodule

[design/bitmap_font_glyph_expander.sv]
// ----------------------------------------------------------------------------
// bitmap_font_glyph_expander
// Renders proportional 1-bit font glyphs into rows of alpha bits.
// ----------------------------------------------------------------------------
// Usage: an item is taken when i_start is high and o_busy is low. Load opcodes
// write the location, strip, spacing or kerning memories; set-pen loads the
// pen. These produce nothing on the o_ ports. A render item produces one
// row beat per glyph line on the o_ ports, marked by o_valid for one cycle;
// the receiver cannot stall, so every beat is simply presented once.
// A render holds o_busy through the location, spacing and kerning lookups
// in S_LOCA, S_LOCB and S_LOCC, then per row through S_FETCH, which reads
// each strip byte spanned (up to 9) in turn, and S_EMIT. The bytes spanned
// per row are ceil((bitoff%8 + shown width)/8), zero for an empty glyph; the
// single read port of the strip memory reads them one by one. The last beat
// is presented in the first cycle in which o_busy is low. Configuration
// writes are taken at any time on the cfg channel (o_cfg_ready is always
// high) and must only be made while idle.
// Reset restores the register defaults and clears the pen; the memories hold
// no defined contents until written and need no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_expander
    import bfge_pkg::*;
#(
    parameter int GLYPH_ENTRIES = 257,
    parameter int FONT_BYTES    = 4096,
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_opcode,
    input  logic [7:0]         i_char_code,
    input  logic [11:0]        i_table_index,
    input  logic [15:0]        i_table_value,
    input  logic signed [15:0] i_pen_x,
    input  logic signed [15:0] i_pen_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_dst_x,
    output logic signed [15:0] o_dst_y,
    output logic [6:0]         o_glyph_width,
    output logic [63:0]        o_row_alpha,
    output logic [5:0]         o_row_number,
    output logic [7:0]         o_row_color,
    output logic               o_last_row,
    output logic signed [15:0] o_next_pen_x
);
    localparam int LD = 2 * GLYPH_ENTRIES;
    localparam int LW = $clog2(LD);
    localparam int GW = $clog2(GLYPH_ENTRIES);

    // Configuration registers.
    logic [7:0]  r_low, r_high, r_ink;
    logic [11:0] r_modulo;
    logic [6:0]  r_height;
    logic [5:0]  r_baseline;
    logic        r_spc_en, r_kern_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= 8'd32; r_high <= 8'd255; r_modulo <= 12'd256;
            r_height <= 7'd8; r_baseline <= 6'd6; r_spc_en <= 1'b0;
            r_kern_en <= 1'b0; r_ink <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOW_CHAR:  r_low      <= i_cfg_data[7:0];
                REG_HIGH_CHAR: r_high     <= i_cfg_data[7:0];
                REG_MODULO:    r_modulo   <= i_cfg_data[11:0];
                REG_HEIGHT:    r_height   <= i_cfg_data[6:0];
                REG_BASELINE:  r_baseline <= i_cfg_data[5:0];
                REG_SPC_EN:    r_spc_en   <= i_cfg_data[0];
                REG_KERN_EN:   r_kern_en  <= i_cfg_data[0];
                REG_INK:       r_ink      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic   accept;
    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);

    // Glyph lookup.
    logic [8:0]  g_calc;
    logic [8:0]  r_g;
    logic        r_gvalid;
    logic [15:0] r_pen_x, r_pen_y;

    always_comb begin
        if ((i_char_code < r_low) || (i_char_code > r_high)) begin
            g_calc = 9'({1'b0, r_high} - {1'b0, r_low} + 9'd1);
        end else begin
            g_calc = 9'({1'b0, i_char_code} - {1'b0, r_low});
        end
    end

    // Location, spacing and kerning memories.
    logic [15:0] loc_mem [LD];
    logic [15:0] spc_mem [GLYPH_ENTRIES];
    logic [15:0] kern_mem [GLYPH_ENTRIES];
    logic [15:0] r_loc_q, r_spc_q, r_kern_q;
    logic [LW-1:0] loc_raddr;
    logic [GW-1:0] g_idx;

    assign g_idx     = r_g[GW-1:0];
    assign loc_raddr = LW'({r_g, (r_state == S_LOCB)});

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_LOC) && ({1'b0, i_table_index} < 13'(LD))) begin
            loc_mem[i_table_index[LW-1:0]] <= i_table_value;
        end
        if (accept && (i_opcode == OP_SPACING) &&
            ({1'b0, i_table_index} < 13'(GLYPH_ENTRIES))) begin
            spc_mem[i_table_index[GW-1:0]] <= i_table_value;
        end
        if (accept && (i_opcode == OP_KERNING) &&
            ({1'b0, i_table_index} < 13'(GLYPH_ENTRIES))) begin
            kern_mem[i_table_index[GW-1:0]] <= i_table_value;
        end
        if ((r_state == S_LOCA) || (r_state == S_LOCB)) begin
            r_loc_q <= loc_mem[loc_raddr];
        end
        if (r_state == S_LOCB) begin
            r_spc_q  <= spc_mem[g_idx];
            r_kern_q <= kern_mem[g_idx];
        end
    end

    // Per-glyph working registers.
    logic [15:0]         r_bitoff;
    logic [6:0]          r_shown;
    logic [5:0]          r_last;
    logic [5:0]          r_row;
    logic [15:0]         r_next_x;
    logic [15:0]         r_ytop;
    logic [3:0]          r_nbytes;
    logic [3:0]          r_k;
    logic [STRIP_AW-1:0] r_rowbase;
    logic [71:0]         r_acc;
    logic                r_rd_vld;
    logic [3:0]          r_rd_idx;

    // Values derived once the width beat lands.
    logic [15:0] width16, adv;
    logic [6:0]  shown_c, height_c;
    logic [7:0]  span;

    always_comb begin
        width16 = r_gvalid ? r_loc_q : 16'd0;
        adv     = r_gvalid ? (r_spc_en ? r_spc_q : width16) : 16'd0;
        if (r_gvalid && r_kern_en) adv = adv + r_kern_q;
        shown_c = (width16 > 16'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width16[6:0];
        if (r_height == 7'd0) begin
            height_c = 7'd1;
        end else if (r_height > 7'(MAX_HEIGHT)) begin
            height_c = 7'(MAX_HEIGHT);
        end else begin
            height_c = r_height;
        end
        if (shown_c == 7'd0) height_c = 7'd1;
        span = (shown_c == 7'd0) ? 8'd0 : 8'({5'd0, r_bitoff[2:0]} + {1'b0, shown_c} + 8'd7);
    end

    // Strip reads.
    logic [7:0]          strip_q;
    logic                strip_re;
    logic [STRIP_AW-1:0] strip_raddr;

    assign strip_re    = (r_state == S_FETCH) && (r_k < r_nbytes);
    assign strip_raddr = r_rowbase + STRIP_AW'(r_k);

    bfge_strip #(.FONT_BYTES(FONT_BYTES)) u_strip (
        .i_clk   (i_clk),
        .i_we    (accept && (i_opcode == OP_FONT)),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value[7:0]),
        .i_re    (strip_re),
        .i_raddr (strip_raddr),
        .o_rdata (strip_q)
    );

    // Row assembly.
    logic [71:0] shifted;
    logic [63:0] mask;
    assign shifted = r_acc << r_bitoff[2:0];
    assign mask    = ~({64{1'b1}} >> r_shown);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && (i_opcode == OP_RENDER)) n_state = S_LOCA;
            S_LOCA:  n_state = S_LOCB;
            S_LOCB:  n_state = S_LOCC;
            S_LOCC:  n_state = S_FETCH;
            S_FETCH: if (r_k == r_nbytes) n_state = S_EMIT;
            S_EMIT:  n_state = (r_row == r_last) ? S_IDLE : S_FETCH;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pen_x  <= 16'd0;
            r_pen_y  <= 16'd0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= strip_re;
            o_valid  <= (r_state == S_EMIT);
            if (accept && (i_opcode == OP_PEN)) begin
                r_pen_x <= i_pen_x;
                r_pen_y <= i_pen_y;
            end
            if ((r_state == S_EMIT) && (r_row == r_last)) r_pen_x <= r_next_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_k;
        if (accept) begin
            r_g      <= g_calc;
            r_gvalid <= ({1'b0, g_calc} < 10'(GLYPH_ENTRIES));
            r_acc    <= 72'd0;
        end
        if (r_state == S_LOCB) r_bitoff <= r_gvalid ? r_loc_q : 16'd0;
        if (r_state == S_LOCC) begin
            r_shown   <= shown_c;
            r_last    <= 6'(height_c - 7'd1);
            r_row     <= 6'd0;
            r_next_x  <= r_pen_x + adv;
            r_ytop    <= r_pen_y - {10'd0, r_baseline};
            r_nbytes  <= span[6:3];
            r_k       <= 4'd0;
            r_rowbase <= STRIP_AW'(r_bitoff[15:3]);
        end
        if (strip_re) r_k <= r_k + 4'd1;
        if (r_rd_vld) begin
            for (int j = 0; j < 9; j++) begin
                if (r_rd_idx == 4'(j)) r_acc[71-8*j -: 8] <= strip_q;
            end
        end
        if (r_state == S_EMIT) begin
            o_dst_x       <= r_pen_x;
            o_dst_y       <= r_ytop + {10'd0, r_row};
            o_glyph_width <= r_shown;
            o_row_alpha   <= shifted[71:8] & mask;
            o_row_number  <= r_row;
            o_row_color   <= r_ink;
            o_last_row    <= (r_row == r_last);
            o_next_pen_x  <= r_next_x;
            r_row         <= r_row + 6'd1;
            r_rowbase     <= r_rowbase + STRIP_AW'(r_modulo);
            r_k           <= 4'd0;
            r_acc         <= 72'd0;
        end
    end

endmodule
